// ===== design/bb3_pkg.sv =====
// shared types and constants for the edge-aware 3x3 box blur
// no dependencies
package bb3_pkg;

    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 18;
    localparam int FWIDTH_W    = 11;
    localparam int FHEIGHT_W   = 13;

    // configuration register indexes
    localparam logic [7:0] CFG_IDX_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_IDX_HEIGHT = 8'd1;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // which window columns (old..new) and rows (top..bottom) lie inside the frame
    typedef struct packed {
        logic [2:0] col_use;
        logic [2:0] row_use;
    } sel_t;

    // ceil(2^RECIP_SHIFT / (2*cnt)) for the neighbor counts that occur
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            4'd1:    m = 18'd131072;
            4'd2:    m = 18'd65536;
            4'd3:    m = 18'd43691;
            4'd4:    m = 18'd32768;
            4'd6:    m = 18'd21846;
            4'd9:    m = 18'd14564;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

// ===== design/bb3_line_mem.sv =====
// synchronous line store memory, one write port and one registered read port
// no dependencies
module bb3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                                 aclk,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/bb3_window.sv =====
// 3x3 window of pixels with masked per-channel sums and neighbor count
// depends on bb3_pkg
module bb3_window (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         shift,
    input  logic [bb3_pkg::PIX_W-1:0]    new_top,
    input  logic [bb3_pkg::PIX_W-1:0]    new_mid,
    input  logic [bb3_pkg::PIX_W-1:0]    new_bot,
    input  bb3_pkg::sel_t                sel,
    output logic [bb3_pkg::SUM_W-1:0]    sum_red,
    output logic [bb3_pkg::SUM_W-1:0]    sum_green,
    output logic [bb3_pkg::SUM_W-1:0]    sum_blue,
    output logic [bb3_pkg::CNT_W-1:0]    cnt
);

    logic [bb3_pkg::PIX_W-1:0]  win_reg  [3][3];
    logic [bb3_pkg::PIX_W-1:0]  win_next [3][3];
    logic [bb3_pkg::SUM_W-1:0]  sum_red_reg, sum_green_reg, sum_blue_reg;
    logic [bb3_pkg::SUM_W-1:0]  sum_red_next, sum_green_next, sum_blue_next;
    logic [bb3_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]                 ncols, nrows;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int r = 0; r < 3; r++) begin
                win_next[c][r] = win_reg[c+1][r];
            end
        end
        win_next[2][0] = new_top;
        win_next[2][1] = new_mid;
        win_next[2][2] = new_bot;
    end

    always_comb begin
        sum_red_next   = '0;
        sum_green_next = '0;
        sum_blue_next  = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (sel.col_use[c] && sel.row_use[r]) begin
                    sum_red_next   = sum_red_next
                                   + bb3_pkg::SUM_W'(win_next[c][r][23:16]);
                    sum_green_next = sum_green_next
                                   + bb3_pkg::SUM_W'(win_next[c][r][15:8]);
                    sum_blue_next  = sum_blue_next
                                   + bb3_pkg::SUM_W'(win_next[c][r][7:0]);
                end
            end
        end
    end

    assign ncols    = 2'd1 + {1'b0, sel.col_use[0]} + {1'b0, sel.col_use[2]};
    assign nrows    = 2'd1 + {1'b0, sel.row_use[0]} + {1'b0, sel.row_use[2]};
    assign cnt_next = {2'b00, ncols} * {2'b00, nrows};

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r] <= '0;
                end
            end
        end else if (shift) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
            cnt_reg       <= cnt_next;
        end
    end

    assign sum_red   = sum_red_reg;
    assign sum_green = sum_green_reg;
    assign sum_blue  = sum_blue_reg;
    assign cnt       = cnt_reg;

endmodule

// ===== design/bb3_round_div.sv =====
// rounded mean of three channel sums by reciprocal multiplication
// depends on bb3_pkg
module bb3_round_div (
    input  logic [bb3_pkg::SUM_W-1:0]  sum_red,
    input  logic [bb3_pkg::SUM_W-1:0]  sum_green,
    input  logic [bb3_pkg::SUM_W-1:0]  sum_blue,
    input  logic [bb3_pkg::CNT_W-1:0]  cnt,
    output logic [bb3_pkg::CHAN_W-1:0] mean_red,
    output logic [bb3_pkg::CHAN_W-1:0] mean_green,
    output logic [bb3_pkg::CHAN_W-1:0] mean_blue
);

    localparam int PROD_W = bb3_pkg::NUM_W + bb3_pkg::RECIP_W;

    logic [bb3_pkg::RECIP_W-1:0] recip;

    // floor((2*sum + cnt) / (2*cnt))
    function automatic logic [bb3_pkg::CHAN_W-1:0] round_mean(
        input logic [bb3_pkg::SUM_W-1:0]   s,
        input logic [bb3_pkg::CNT_W-1:0]   c,
        input logic [bb3_pkg::RECIP_W-1:0] m
    );
        logic [bb3_pkg::NUM_W-1:0] num;
        logic [PROD_W-1:0]         prod;
        num  = {s, 1'b0} + bb3_pkg::NUM_W'(c);
        prod = PROD_W'(num) * PROD_W'(m);
        return prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
    endfunction

    assign recip      = bb3_pkg::recip_of(cnt);
    assign mean_red   = round_mean(sum_red, cnt, recip);
    assign mean_green = round_mean(sum_green, cnt, recip);
    assign mean_blue  = round_mean(sum_blue, cnt, recip);

endmodule

// ===== design/box_blur_3x3_edge_aware.sv =====
// top level of the edge-aware 3x3 box blur over a raster-order rgb stream
// depends on bb3_pkg, bb3_line_mem, bb3_window, bb3_round_div
//
// s_* carries one transfer per pixel (s_kind = 0) or flush tick (s_kind = 1).
// m_* carries the blurred pixels; m_end_of_frame marks the last of a frame.
// cfg_* writes frame_width (index 0) or frame_height (index 1); a write
// restarts the frame and clears the window, the line stores keep their data.
// write configuration only while the block is idle; cfg_ready is always high.
// output k of a frame comes with input transfer k + width + 1, so a frame
// needs width + 1 flush ticks after its last pixel.
// an item reads the line store in idle, writes it back and sums the window
// in rmw, and goes through the reciprocal multiply into the output register
// in div. items without a result skip div; ignored flush ticks stay in idle.
// the output register holds a result while the next item is taken in; a
// stalled receiver holds the block only when a second result is ready.
// after reset width is 640, height 480, counters and window are zero; the
// line stores need no clearing since every entry is written before use.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_in_red,
    input  logic [7:0]  s_in_green,
    input  logic [7:0]  s_in_blue,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_blue,
    output logic        m_end_of_frame,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = bb3_pkg::FWIDTH_W;
    localparam int HW = bb3_pkg::FHEIGHT_W;
    localparam logic [WW-1:0] WIDTH_CAP =
        (MAX_WIDTH > 2047) ? 11'd2047 : WW'(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RMW,
        ST_DIV
    } state_t;

    state_t                      state_reg;
    logic [WW-1:0]               width_reg;
    logic [HW-1:0]               height_reg;
    logic [WW-1:0]               in_col_reg;
    logic [HW:0]                 in_row_reg;
    logic [WW:0]                 lag_reg;
    logic [WW-1:0]               out_col_reg;
    logic [HW-1:0]               out_row_reg;
    logic [WW-1:0]               col_addr_reg;
    logic [bb3_pkg::PIX_W-1:0]   pix_reg;
    logic                        emit_reg;
    logic                        last_reg;
    bb3_pkg::sel_t               sel_reg;
    logic                        m_valid_reg;
    logic [7:0]                  m_red_reg, m_green_reg, m_blue_reg;
    logic                        m_eof_reg;

    logic [WW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;
    logic                        frame_done;
    logic                        ignore;
    logic                        emit;
    logic                        last;
    logic                        s_xfer;
    logic                        work;
    logic                        cfg_xfer;
    logic                        restart;
    logic                        out_free;
    bb3_pkg::sel_t               sel_now;

    logic [2*bb3_pkg::PIX_W-1:0] rd_data;
    logic [bb3_pkg::PIX_W-1:0]   rd_upper, rd_middle;
    logic [bb3_pkg::SUM_W-1:0]   sum_red, sum_green, sum_blue;
    logic [bb3_pkg::CNT_W-1:0]   cnt;
    logic [7:0]                  mean_red, mean_green, mean_blue;

    assign eff_w = (width_reg == '0) ? WW'(1) :
                   (width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg;
    assign eff_h = (height_reg == '0) ? HW'(1) : height_reg;

    assign frame_done = in_row_reg >= {1'b0, eff_h};
    assign ignore     = (s_kind == bb3_pkg::KIND_FLUSH) && !frame_done;
    assign emit       = lag_reg == ({1'b0, eff_w} + (WW+1)'(1));
    assign last       = (out_col_reg == eff_w - WW'(1)) && (out_row_reg == eff_h - HW'(1));

    assign s_ready  = state_reg == ST_IDLE;
    assign s_xfer   = s_valid && s_ready;
    assign work     = s_xfer && !ignore;
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign restart  = cfg_xfer && (cfg_index == bb3_pkg::CFG_IDX_WIDTH ||
                                   cfg_index == bb3_pkg::CFG_IDX_HEIGHT);
    assign out_free = !m_valid_reg || m_ready;

    assign sel_now.col_use = {({1'b0, out_col_reg} + (WW+1)'(1)) < {1'b0, eff_w},
                              1'b1, out_col_reg != '0};
    assign sel_now.row_use = {({1'b0, out_row_reg} + (HW+1)'(1)) < {1'b0, eff_h},
                              1'b1, out_row_reg != '0};

    assign rd_upper  = rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
    assign rd_middle = rd_data[bb3_pkg::PIX_W-1:0];

    bb3_line_mem #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2*bb3_pkg::PIX_W)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (work),
        .rd_addr (AW'(in_col_reg)),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_RMW),
        .wr_addr (AW'(col_addr_reg)),
        .wr_data ({rd_middle, pix_reg})
    );

    bb3_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (restart),
        .shift     (state_reg == ST_RMW),
        .new_top   (rd_upper),
        .new_mid   (rd_middle),
        .new_bot   (pix_reg),
        .sel       (sel_reg),
        .sum_red   (sum_red),
        .sum_green (sum_green),
        .sum_blue  (sum_blue),
        .cnt       (cnt)
    );

    bb3_round_div u_round_div (
        .sum_red    (sum_red),
        .sum_green  (sum_green),
        .sum_blue   (sum_blue),
        .cnt        (cnt),
        .mean_red   (mean_red),
        .mean_green (mean_green),
        .mean_blue  (mean_blue)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= 11'd640;
            height_reg  <= 13'd480;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            lag_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DIV && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (restart) begin
                if (cfg_index == bb3_pkg::CFG_IDX_WIDTH) begin
                    width_reg <= cfg_data[WW-1:0];
                end else begin
                    height_reg <= cfg_data[HW-1:0];
                end
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                lag_reg     <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                unique case (state_reg)
                    ST_IDLE: begin
                        if (work) begin
                            col_addr_reg <= in_col_reg;
                            pix_reg      <= frame_done ? '0 :
                                            {s_in_red, s_in_green, s_in_blue};
                            emit_reg     <= emit;
                            last_reg     <= last;
                            sel_reg      <= sel_now;
                            state_reg    <= ST_RMW;

                            if (emit && last) begin
                                in_col_reg  <= '0;
                                in_row_reg  <= '0;
                                lag_reg     <= '0;
                                out_col_reg <= '0;
                                out_row_reg <= '0;
                            end else begin
                                if (({1'b0, in_col_reg} + (WW+1)'(1)) >= {1'b0, eff_w}) begin
                                    in_col_reg <= '0;
                                    in_row_reg <= in_row_reg + (HW+1)'(1);
                                end else begin
                                    in_col_reg <= in_col_reg + WW'(1);
                                end

                                if (!emit) begin
                                    lag_reg <= lag_reg + (WW+1)'(1);
                                end else if ((out_col_reg + WW'(1)) == eff_w) begin
                                    out_col_reg <= '0;
                                    out_row_reg <= out_row_reg + HW'(1);
                                end else begin
                                    out_col_reg <= out_col_reg + WW'(1);
                                end
                            end
                        end
                    end
                    ST_RMW: begin
                        state_reg <= emit_reg ? ST_DIV : ST_IDLE;
                    end
                    ST_DIV: begin
                        if (out_free) begin
                            m_red_reg   <= mean_red;
                            m_green_reg <= mean_green;
                            m_blue_reg  <= mean_blue;
                            m_eof_reg   <= last_reg;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_red      = m_red_reg;
    assign m_out_green    = m_green_reg;
    assign m_out_blue     = m_blue_reg;
    assign m_end_of_frame = m_eof_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for box_blur_3x3_edge_aware: random and directed frames
// checked against an in-bench line-buffer predictor; depends on bb3_pkg and the design
module tb;

    localparam int          LINE_DEPTH       = 1024;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          RANDOM_ITEMS     = 110;
    localparam logic [7:0]  REG_FRAME_WIDTH  = bb3_pkg::CFG_IDX_WIDTH;
    localparam logic [7:0]  REG_FRAME_HEIGHT = bb3_pkg::CFG_IDX_HEIGHT;
    localparam logic        KIND_PIXEL       = bb3_pkg::KIND_PIXEL;
    localparam logic        KIND_FLUSH       = bb3_pkg::KIND_FLUSH;

    typedef struct packed {
        logic [bb3_pkg::CHAN_W-1:0] red;
        logic [bb3_pkg::CHAN_W-1:0] green;
        logic [bb3_pkg::CHAN_W-1:0] blue;
        logic                       eof;
    } blur_px_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [7:0]  s_in_red;
    logic [7:0]  s_in_green;
    logic [7:0]  s_in_blue;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_red;
    logic [7:0]  m_out_green;
    logic [7:0]  m_out_blue;
    logic        m_end_of_frame;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    logic [bb3_pkg::FWIDTH_W-1:0]  cur_width  = 11'd640;
    logic [bb3_pkg::FHEIGHT_W-1:0] cur_height = 13'd480;
    bit [bb3_pkg::PIX_W-1:0]       older_row_mem [LINE_DEPTH];
    bit [bb3_pkg::PIX_W-1:0]       newer_row_mem [LINE_DEPTH];
    bit [bb3_pkg::PIX_W-1:0]       win_px [3][3];
    int unsigned                   in_col;
    int unsigned                   in_row;
    int unsigned                   out_pos;

    blur_px_t blurred_q [$];
    blur_px_t want;
    int       mismatches = 0;
    int       items_sent = 0;
    int       tx_pct = 0;
    int       rx_pct = 0;
    int       rx_hold = 0;

    box_blur_3x3_edge_aware #(.MAX_WIDTH(LINE_DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_in_red       (s_in_red),
        .s_in_green     (s_in_green),
        .s_in_blue      (s_in_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_end_of_frame (m_end_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned line_width();
        if (cur_width == 0) return 1;
        if (cur_width > LINE_DEPTH) return LINE_DEPTH;
        return 32'(cur_width);
    endfunction

    function automatic int unsigned frame_lines();
        return (cur_height == 0) ? 1 : 32'(cur_height);
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    function automatic logic [7:0] rnd_chan();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic restart_frame();
        int i;
        int j;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                win_px[i][j] = '0;
        in_col  = 0;
        in_row  = 0;
        out_pos = 0;
    endtask

    task automatic blur_set_reg(input logic [7:0] idx, input logic [15:0] val);
        if (idx == REG_FRAME_WIDTH) begin
            cur_width = val[bb3_pkg::FWIDTH_W-1:0];
            restart_frame();
        end else if (idx == REG_FRAME_HEIGHT) begin
            cur_height = val[bb3_pkg::FHEIGHT_W-1:0];
            restart_frame();
        end
    endtask

    task automatic blur_predict(input logic kind, input logic [7:0] r, g, b);
        int unsigned w, h, lin, col, pos, orow, ocol, c0, c1, r0, r1;
        int unsigned cnt, sr, sg, sb, i, j;
        logic [bb3_pkg::PIX_W-1:0] pix, top, mid;
        logic done;
        blur_px_t px;
        w = line_width();
        h = frame_lines();
        done = (in_row >= h);
        if (kind == KIND_FLUSH && !done) return;
        lin = in_row * w + in_col;
        pix = done ? '0 : {r, g, b};
        col = (in_col < LINE_DEPTH) ? in_col : 0;
        top = older_row_mem[col];
        mid = newer_row_mem[col];
        older_row_mem[col] = mid;
        newer_row_mem[col] = pix;
        for (i = 0; i < 3; i++) begin
            win_px[0][i] = win_px[1][i];
            win_px[1][i] = win_px[2][i];
        end
        win_px[2][0] = top;
        win_px[2][1] = mid;
        win_px[2][2] = pix;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (lin < w + 1) return;
        pos  = out_pos;
        orow = pos / w;
        ocol = pos % w;
        c0 = (ocol > 0) ? 0 : 1;
        c1 = (ocol + 1 < w) ? 2 : 1;
        r0 = (orow > 0) ? 0 : 1;
        r1 = (orow + 1 < h) ? 2 : 1;
        sr = 0;
        sg = 0;
        sb = 0;
        for (i = c0; i <= c1; i++)
            for (j = r0; j <= r1; j++) begin
                sr += win_px[i][j][23:16];
                sg += win_px[i][j][15:8];
                sb += win_px[i][j][7:0];
            end
        cnt = (c1 - c0 + 1) * (r1 - r0 + 1);
        px.red   = 8'((2 * sr + cnt) / (2 * cnt));
        px.green = 8'((2 * sg + cnt) / (2 * cnt));
        px.blue  = 8'((2 * sb + cnt) / (2 * cnt));
        px.eof   = (pos + 1 >= w * h);
        blurred_q.push_back(px);
        out_pos = pos + 1;
        if (px.eof) begin
            in_col  = 0;
            in_row  = 0;
            out_pos = 0;
        end
    endtask

    // one input transfer, with a random gap in front
    task automatic send_item(input logic kind, input logic [7:0] r, g, b);
        int gap;
        gap = pick_gap(tx_pct);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_in_red   <= r;
        s_in_green <= g;
        s_in_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        blur_predict(kind, r, g, b);
        items_sent++;
    endtask

    // sender stops until every expected result is back
    task automatic drain_wait();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        blur_set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixels(input int count, input int pause_at);
        int i;
        for (i = 0; i < count; i++) begin
            if (i == pause_at) drain_wait();
            if ($urandom_range(0, 24) == 0)
                send_item(KIND_FLUSH, rnd_chan(), rnd_chan(), rnd_chan());
            send_item(KIND_PIXEL, rnd_chan(), rnd_chan(), rnd_chan());
        end
    endtask

    // width + 1 drain transfers, some of them pixels past the frame, then stray ticks
    task automatic send_tail(input int w);
        int i;
        for (i = 0; i <= w; i++)
            send_item(($urandom_range(0, 4) == 0) ? KIND_PIXEL : KIND_FLUSH,
                      rnd_chan(), rnd_chan(), rnd_chan());
        repeat ($urandom_range(0, 2))
            send_item(KIND_FLUSH, rnd_chan(), rnd_chan(), rnd_chan());
    endtask

    task automatic test_reset_defaults();
        tx_pct = 15;
        rx_pct = 15;
        send_pixels(643, -1);
        drain_wait();
    endtask

    task automatic test_corner_cases();
        int i;
        tx_pct = 0;
        rx_pct = 0;
        // zero width and height act as a single pixel
        cfg_write(REG_FRAME_WIDTH, 16'd0);
        cfg_write(REG_FRAME_HEIGHT, 16'd0);
        send_item(KIND_PIXEL, 8'hff, 8'h00, 8'h80);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_FLUSH, 8'hff, 8'hff, 8'hff);
        send_item(KIND_FLUSH, 8'hff, 8'hff, 8'hff);
        send_item(KIND_PIXEL, 8'h00, 8'hff, 8'h7f);
        send_item(KIND_PIXEL, 8'haa, 8'h55, 8'hff);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        drain_wait();
        // rounding on a 3x2 frame with a tick inside the frame
        cfg_write(REG_FRAME_WIDTH, 16'd3);
        cfg_write(REG_FRAME_HEIGHT, 16'd2);
        for (i = 0; i < 6; i++) begin
            if (i == 3) send_item(KIND_FLUSH, 8'h12, 8'h34, 8'h56);
            send_item(KIND_PIXEL, i[0] ? 8'd255 : 8'd0, 8'(i * 51), (i == 0) ? 8'd1 : 8'd0);
        end
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_PIXEL, 8'hff, 8'hff, 8'hff);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(KIND_FLUSH, 8'h00, 8'h00, 8'h00);
        drain_wait();
        // writes to unused indexes change nothing
        cfg_write(8'd2, 16'hffff);
        cfg_write(8'd255, 16'h0000);
        send_item(KIND_PIXEL, 8'd10, 8'd20, 8'd30);
        send_item(KIND_PIXEL, 8'd11, 8'd21, 8'd31);
        send_item(KIND_PIXEL, 8'd12, 8'd22, 8'd32);
        drain_wait();
    endtask

    task automatic test_height_range();
        tx_pct = 15;
        rx_pct = 15;
        cfg_write(REG_FRAME_WIDTH, 16'd1);
        cfg_write(REG_FRAME_HEIGHT, 16'd4096);
        send_pixels(12, -1);
        drain_wait();
        cfg_write(REG_FRAME_HEIGHT, 16'hffff);
        send_pixels(8, -1);
        drain_wait();
    endtask

    task automatic test_widest_line();
        tx_pct = 10;
        rx_pct = 10;
        // all-ones width is clamped to the line store depth, frame left unfinished
        cfg_write(REG_FRAME_WIDTH, 16'hffff);
        cfg_write(REG_FRAME_HEIGHT, 16'd2);
        send_pixels(LINE_DEPTH + 3, -1);
        drain_wait();
    endtask

    task automatic test_output_stall();
        tx_pct = 0;
        rx_pct = 0;
        cfg_write(REG_FRAME_WIDTH, 16'd8);
        cfg_write(REG_FRAME_HEIGHT, 16'd6);
        rx_hold = 200;
        send_pixels(48, 30);
        send_tail(8);
        drain_wait();
    endtask

    task automatic test_random_frames();
        int base, fw, fh, npix, count, pause_at;
        logic need_cfg;
        base = items_sent;
        need_cfg = 1'b1;
        fw = 1;
        fh = 1;
        while (items_sent - base < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0)
                cfg_write(8'($urandom_range(2, 255)), 16'($urandom()));
            if (need_cfg || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: begin fw = 1; fh = $urandom_range(1, 30); end
                    1: begin fw = $urandom_range(1, 30); fh = 1; end
                    2: begin fw = $urandom_range(13, 48); fh = $urandom_range(2, 4); end
                    default: begin fw = $urandom_range(2, 12); fh = $urandom_range(2, 10); end
                endcase
                cfg_write(REG_FRAME_WIDTH, {5'($urandom_range(0, 31)), 11'(fw)});
                cfg_write(REG_FRAME_HEIGHT, {3'($urandom_range(0, 7)), 13'(fh)});
            end
            tx_pct = pick_idle();
            rx_pct = pick_idle();
            npix = fw * fh;
            pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1) : -1;
            if ($urandom_range(0, 11) == 0) begin
                // abandoned frame, the next pass brings the block back with a register write
                count = $urandom_range(0, npix - 1);
                send_pixels(count, pause_at);
                need_cfg = 1'b1;
            end else begin
                send_pixels(npix, pause_at);
                send_tail(fw);
                need_cfg = 1'b0;
            end
            drain_wait();
        end
    endtask

    // receiver side: random stalls plus a long hold when asked
    initial begin : rx_side
        int gap;
        gap = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                gap = pick_gap(rx_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (blurred_q.size() == 0) begin
                $error("output transfer with no pixel expected");
                mismatches++;
            end else begin
                want = blurred_q.pop_front();
                if (m_out_red !== want.red) begin
                    $error("out_red: expected %0d, got %0d", want.red, m_out_red);
                    mismatches++;
                end
                if (m_out_green !== want.green) begin
                    $error("out_green: expected %0d, got %0d", want.green, m_out_green);
                    mismatches++;
                end
                if (m_out_blue !== want.blue) begin
                    $error("out_blue: expected %0d, got %0d", want.blue, m_out_blue);
                    mismatches++;
                end
                if (m_end_of_frame !== want.eof) begin
                    $error("end_of_frame: expected %0d, got %0d", want.eof, m_end_of_frame);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_kind     = KIND_PIXEL;
        s_in_red   = '0;
        s_in_green = '0;
        s_in_blue  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_FRAME_WIDTH;
        cfg_data   = '0;
        restart_frame();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_corner_cases();
        test_height_range();
        test_output_stall();
        test_widest_line();
        test_random_frames();
        drain_wait();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== box_blur_3x3_edge_aware.f =====
design/bb3_pkg.sv
design/bb3_line_mem.sv
design/bb3_window.sv
design/bb3_round_div.sv
design/box_blur_3x3_edge_aware.sv
test/tb.sv
